// ===== rtl/core/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants of the strict priority ready select block:
// field widths, operation codes and the rank compare result.
// ----------------------------------------------------------------------------
`default_nettype none

package spr_pkg;

    // fixed field widths of the item and result channels
    localparam int SOCKET_W     = 6;
    localparam int CLIENT_OUT_W = 7;
    localparam int RANK_W       = 16;
    localparam int MASK_W       = 64;

    // operation codes carried by an input item
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SCAN  = 1'b1;

    // result of the shared rank comparator
    typedef struct packed {
        logic greater;
        logic equal;
    } rank_cmp_t;

endpackage

`default_nettype wire

// ===== rtl/core/spr_ram.sv =====
// ----------------------------------------------------------------------------
// spr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/spr_rank_cmp.sv =====
// ----------------------------------------------------------------------------
// spr_rank_cmp
// Shared signed rank comparator, used by both the search pass and the
// emit pass of a scan.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_rank_cmp (
    input  wire logic signed [spr_pkg::RANK_W-1:0] rank,
    input  wire logic signed [spr_pkg::RANK_W-1:0] best,
    output spr_pkg::rank_cmp_t                     res
);

    // one signed compare, greater and equal flags
    always_comb begin
        res.greater = (rank > best);
        res.equal   = (rank == best);
    end

endmodule

`default_nettype wire

// ===== rtl/core/spr_scan_seq.sv =====
// ----------------------------------------------------------------------------
// spr_scan_seq
// Scan sequencer: walks the socket table once to find the greatest ready
// rank (strict mode only) and count the selected sockets, then walks it
// again and emits each selected client through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_scan_seq #(
    parameter int SOCKET_COUNT      = 64,
    parameter int CLIENT_INDEX_BITS = 7
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  strict_mode,
    // input item handshake
    input  wire logic                                  s_valid,
    input  wire logic                                  s_operation,
    input  wire logic [spr_pkg::MASK_W-1:0]            s_ready_mask,
    output logic                                       s_ready,
    // table read port
    output logic [$clog2(SOCKET_COUNT)-1:0]            rd_addr,
    input  wire logic [CLIENT_INDEX_BITS-1:0]          rd_client,
    input  wire logic signed [spr_pkg::RANK_W-1:0]     rd_rank,
    // result item channel
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [spr_pkg::CLIENT_OUT_W-1:0]           m_ready_client,
    output logic                                       m_present,
    output logic                                       m_last_of_run
);

    localparam int IDX_W = $clog2(SOCKET_COUNT);
    localparam int CNT_W = $clog2(SOCKET_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SOCKET_COUNT - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_EMIT,
        S_EMPTY
    } state_t;

    state_t                             state_reg, state_next;
    logic [IDX_W-1:0]                   idx_reg, idx_next;
    logic [SOCKET_COUNT-1:0]            ready_reg, ready_next;
    logic signed [spr_pkg::RANK_W-1:0]  best_reg, best_next;
    logic                               have_reg, have_next;
    logic [CNT_W-1:0]                   sel_cnt_reg, sel_cnt_next;
    logic [CNT_W-1:0]                   emit_cnt_reg, emit_cnt_next;
    logic                               m_valid_reg, m_valid_next;
    logic [spr_pkg::CLIENT_OUT_W-1:0]   m_client_reg, m_client_next;
    logic                               m_present_reg, m_present_next;
    logic                               m_last_reg, m_last_next;

    spr_pkg::rank_cmp_t                 cmp;
    logic [SOCKET_COUNT-1:0]            mask_in;
    logic                               out_free;
    logic                               sel;
    logic                               is_last;

    // shared rank comparator
    spr_rank_cmp u_cmp (
        .rank (rd_rank),
        .best (best_reg),
        .res  (cmp)
    );

    // ready bits beyond the socket count are dropped
    assign mask_in  = s_ready_mask[SOCKET_COUNT-1:0];
    assign out_free = !m_valid_reg || m_ready;
    assign sel      = ready_reg[idx_reg] && (!strict_mode || cmp.equal);
    assign is_last  = (CNT_W'(emit_cnt_reg + CNT_W'(1)) == sel_cnt_reg);

    // next state and datapath control
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        ready_next     = ready_reg;
        best_next      = best_reg;
        have_next      = have_reg;
        sel_cnt_next   = sel_cnt_reg;
        emit_cnt_next  = emit_cnt_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_client_next  = m_client_reg;
        m_present_next = m_present_reg;
        m_last_next    = m_last_reg;

        case (state_reg)
            S_IDLE: begin
                idx_next = '0;
                if (s_valid && (s_operation == spr_pkg::OP_SCAN)) begin
                    ready_next    = mask_in;
                    have_next     = 1'b0;
                    sel_cnt_next  = '0;
                    emit_cnt_next = '0;
                    state_next    = (mask_in == '0) ? S_EMPTY : S_FIND;
                end
            end
            // search pass: greatest ready rank and number of selected sockets
            S_FIND: begin
                if (ready_reg[idx_reg]) begin
                    if (!strict_mode) begin
                        sel_cnt_next = CNT_W'(sel_cnt_reg + CNT_W'(1));
                    end else if (!have_reg || cmp.greater) begin
                        best_next    = rd_rank;
                        have_next    = 1'b1;
                        sel_cnt_next = CNT_W'(1);
                    end else if (cmp.equal) begin
                        sel_cnt_next = CNT_W'(sel_cnt_reg + CNT_W'(1));
                    end
                end
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = S_EMIT;
                end else begin
                    idx_next = IDX_W'(idx_reg + IDX_W'(1));
                end
            end
            // emit pass: one selected socket per cycle, holds on a full output
            S_EMIT: begin
                if (sel) begin
                    if (out_free) begin
                        m_valid_next   = 1'b1;
                        m_client_next  = spr_pkg::CLIENT_OUT_W'(rd_client);
                        m_present_next = 1'b1;
                        m_last_next    = is_last;
                        emit_cnt_next  = CNT_W'(emit_cnt_reg + CNT_W'(1));
                        if (is_last || (idx_reg == LAST_IDX)) begin
                            state_next = S_IDLE;
                        end else begin
                            idx_next = IDX_W'(idx_reg + IDX_W'(1));
                        end
                    end
                end else if (idx_reg == LAST_IDX) begin
                    state_next = S_IDLE;
                end else begin
                    idx_next = IDX_W'(idx_reg + IDX_W'(1));
                end
            end
            // empty mask: one result with present clear
            S_EMPTY: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_client_next  = '0;
                    m_present_next = 1'b0;
                    m_last_next    = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        ready_reg     <= ready_next;
        best_reg      <= best_next;
        have_reg      <= have_next;
        sel_cnt_reg   <= sel_cnt_next;
        emit_cnt_reg  <= emit_cnt_next;
        m_client_reg  <= m_client_next;
        m_present_reg <= m_present_next;
        m_last_reg    <= m_last_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // read address follows the next index so data lines up with idx_reg
    assign rd_addr        = idx_next;
    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_ready_client = m_client_reg;
    assign m_present      = m_present_reg;
    assign m_last_of_run  = m_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/strict_priority_ready_select.sv =====
// Write item: accepted while idle, no result.
// Scan item: a rank search pass over the table through the RAM read port,
// then an emit pass that returns the selected clients and holds while the
// output is stalled; no new item is accepted until the emit pass is over.
// Empty scan: a single result with present clear, from the S_EMPTY state.
// Reset: synchronous active low; strict_mode returns to 1, table undefined.
// ----------------------------------------------------------------------------
// strict_priority_ready_select
// Socket table of client index and rank, with scans of a ready mask that
// return the clients of the highest ranked (or all) ready sockets in order.
// ----------------------------------------------------------------------------
`default_nettype none

module strict_priority_ready_select #(
    parameter int SOCKET_COUNT      = 64,
    parameter int CLIENT_INDEX_BITS = 7
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration write channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic                                 cfg_data,
    // input item channel
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_operation,
    input  wire logic [spr_pkg::SOCKET_W-1:0]         s_socket,
    input  wire logic [spr_pkg::CLIENT_OUT_W-1:0]     s_client_number,
    input  wire logic signed [spr_pkg::RANK_W-1:0]    s_client_rank,
    input  wire logic [spr_pkg::MASK_W-1:0]           s_ready_mask,
    // result item channel
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [spr_pkg::CLIENT_OUT_W-1:0]          m_ready_client,
    output logic                                      m_present,
    output logic                                      m_last_of_run
);

    localparam int IDX_W  = $clog2(SOCKET_COUNT);
    localparam int WORD_W = CLIENT_INDEX_BITS + spr_pkg::RANK_W;

    logic                                strict_mode_reg;
    logic                                wr_en;
    logic [IDX_W-1:0]                    rd_addr;
    logic [WORD_W-1:0]                   wr_word;
    logic [WORD_W-1:0]                   rd_word;
    logic [CLIENT_INDEX_BITS-1:0]        rd_client;
    logic signed [spr_pkg::RANK_W-1:0]   rd_rank;

    // mode register, always ready for a write
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strict_mode_reg <= 1'b1;
        end else if (cfg_valid) begin
            strict_mode_reg <= cfg_data;
        end
    end

    // table write on an accepted write item for a socket in range
    assign wr_en = s_valid && s_ready && (s_operation == spr_pkg::OP_WRITE)
                   && ({1'b0, s_socket} < (spr_pkg::SOCKET_W + 1)'(SOCKET_COUNT));
    assign wr_word = {CLIENT_INDEX_BITS'(s_client_number), s_client_rank};

    spr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SOCKET_COUNT)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s_socket[IDX_W-1:0]),
        .wr_data (wr_word),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    assign rd_client = rd_word[WORD_W-1:spr_pkg::RANK_W];
    assign rd_rank   = rd_word[spr_pkg::RANK_W-1:0];

    // scan sequencer and output stage
    spr_scan_seq #(
        .SOCKET_COUNT      (SOCKET_COUNT),
        .CLIENT_INDEX_BITS (CLIENT_INDEX_BITS)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .strict_mode    (strict_mode_reg),
        .s_valid        (s_valid),
        .s_operation    (s_operation),
        .s_ready_mask   (s_ready_mask),
        .s_ready        (s_ready),
        .rd_addr        (rd_addr),
        .rd_client      (rd_client),
        .rd_rank        (rd_rank),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ready_client (m_ready_client),
        .m_present      (m_present),
        .m_last_of_run  (m_last_of_run)
    );

endmodule

`default_nettype wire

// ===== bench/strict_priority_ready_select_checker.sv =====
// ----------------------------------------------------------------------------
// strict_priority_ready_select_checker
// Follows the mode register, the item and the result channels of the ready
// select block, keeps its own socket table, predicts the clients that every
// scan returns and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module strict_priority_ready_select_checker import spr_pkg::*; #(
    parameter int SOCKET_COUNT      = 64,
    parameter int CLIENT_INDEX_BITS = 7
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic                      cfg_data,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic                      s_operation,
    input  logic [SOCKET_W-1:0]       s_socket,
    input  logic [CLIENT_OUT_W-1:0]   s_client_number,
    input  logic signed [RANK_W-1:0]  s_client_rank,
    input  logic [MASK_W-1:0]         s_ready_mask,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic [CLIENT_OUT_W-1:0]   m_ready_client,
    input  logic                      m_present,
    input  logic                      m_last_of_run,
    output int                        mismatch_count,
    output int                        results_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // sockets that exist in this configuration of the block
    localparam logic [MASK_W-1:0] SOCKET_RANGE = (SOCKET_COUNT >= MASK_W) ?
        {MASK_W{1'b1}} : ((64'd1 << SOCKET_COUNT) - 64'd1);
    // stored client index keeps only the configured number of bits
    localparam logic [CLIENT_OUT_W-1:0] CLIENT_KEEP = (CLIENT_INDEX_BITS >= CLIENT_OUT_W) ?
        {CLIENT_OUT_W{1'b1}} : CLIENT_OUT_W'((1 << CLIENT_INDEX_BITS) - 1);

    typedef struct packed {
        logic [CLIENT_OUT_W-1:0] ready_client;
        logic                    present;
        logic                    last_of_run;
    } client_result_t;

    logic                      strict_mode;
    logic [CLIENT_OUT_W-1:0]   client_of_socket [SOCKET_COUNT];
    logic signed [RANK_W-1:0]  rank_of_socket [SOCKET_COUNT];
    client_result_t            expected_clients [$];

    // queue the clients one scan of the ready mask returns
    function automatic void select_ready_clients(input logic [MASK_W-1:0] ready_mask);
        logic [MASK_W-1:0]        live;
        logic [MASK_W-1:0]        chosen;
        logic signed [RANK_W-1:0] top_rank;
        bit                       found;
        client_result_t           entry;
        live     = ready_mask & SOCKET_RANGE;
        chosen   = '0;
        top_rank = '0;
        found    = 1'b0;
        // nothing ready: one empty result closes the scan
        if (live == '0) begin
            entry.ready_client = '0;
            entry.present      = 1'b0;
            entry.last_of_run  = 1'b1;
            expected_clients.push_back(entry);
            return;
        end
        // greatest rank among the ready sockets
        if (strict_mode) begin
            for (int s = 0; s < SOCKET_COUNT; s++) begin
                if (live[s] && (!found || rank_of_socket[s] > top_rank)) begin
                    top_rank = rank_of_socket[s];
                    found    = 1'b1;
                end
            end
        end
        for (int s = 0; s < SOCKET_COUNT; s++) begin
            if (live[s] && (!strict_mode || rank_of_socket[s] == top_rank))
                chosen[s] = 1'b1;
        end
        // ascending socket order, last flag on the highest chosen socket
        for (int s = 0; s < SOCKET_COUNT; s++) begin
            if (chosen[s]) begin
                entry.ready_client = client_of_socket[s];
                entry.present      = 1'b1;
                entry.last_of_run  = ((chosen >> (s + 1)) == '0);
                expected_clients.push_back(entry);
            end
        end
    endfunction

    function automatic int field_differs(input string field,
                                         input logic [CLIENT_OUT_W-1:0] want,
                                         input logic [CLIENT_OUT_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            return 1;
        end
        return 0;
    endfunction

    // follow every handshake of the three channels
    always @(posedge aclk) begin
        client_result_t want;
        int             misses;
        misses = 0;
        if (!aresetn) begin
            strict_mode = 1'b1;
            for (int s = 0; s < SOCKET_COUNT; s++) begin
                client_of_socket[s] = '0;
                rank_of_socket[s]   = '0;
            end
            expected_clients.delete();
            mismatch_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready)
                strict_mode = cfg_data;
            // table write or scan item
            if (s_valid && s_ready) begin
                if (s_operation == OP_WRITE) begin
                    if (s_socket < SOCKET_COUNT) begin
                        client_of_socket[s_socket] = s_client_number & CLIENT_KEEP;
                        rank_of_socket[s_socket]   = s_client_rank;
                    end
                end else begin
                    select_ready_clients(s_ready_mask);
                end
            end
            // result item against the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_clients.size() == 0) begin
                    $error("unexpected result item: client %0d, present %0b, last %0b",
                           m_ready_client, m_present, m_last_of_run);
                    misses = 1;
                end else begin
                    want = expected_clients.pop_front();
                    misses += field_differs("ready_client", want.ready_client,
                                            m_ready_client);
                    misses += field_differs("present", CLIENT_OUT_W'(want.present),
                                            CLIENT_OUT_W'(m_present));
                    misses += field_differs("last_of_run", CLIENT_OUT_W'(want.last_of_run),
                                            CLIENT_OUT_W'(m_last_of_run));
                end
            end
            mismatch_count <= mismatch_count + misses;
        end
        results_outstanding <= expected_clients.size();
    end

endmodule

// ===== bench/strict_priority_ready_select_test.sv =====
// ----------------------------------------------------------------------------
// strict_priority_ready_select_test
// Drives table writes and ready mask scans into the ready select block under
// both settings of the strict mode register, with random idling on both
// channels and one long result stall, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module strict_priority_ready_select_test;
    timeunit 1ns;
    timeprecision 1ps;
    import spr_pkg::*;

    localparam int SOCKET_COUNT      = 64;
    localparam int CLIENT_INDEX_BITS = 7;
    localparam int CLK_PERIOD        = 12;
    localparam int PHASE_COUNT       = 5;
    localparam int PHASE_ITEMS       = 78;
    // strict mode of each random phase, phase 0 in bit 0
    localparam logic [PHASE_COUNT-1:0] PHASE_STRICT = 5'b10101;
    localparam int SETTLE_CYCLES     = SOCKET_COUNT + 8;
    localparam int PRESSURE_CYCLES   = 400;
    localparam int LIMIT_CYCLES      = 1_000_000;

    logic                      aclk            = 1'b0;
    logic                      aresetn         = 1'b0;
    logic                      cfg_valid       = 1'b0;
    logic                      cfg_ready;
    logic                      cfg_data        = 1'b0;
    logic                      s_valid         = 1'b0;
    logic                      s_ready;
    logic                      s_operation     = OP_WRITE;
    logic [SOCKET_W-1:0]       s_socket        = '0;
    logic [CLIENT_OUT_W-1:0]   s_client_number = '0;
    logic signed [RANK_W-1:0]  s_client_rank   = '0;
    logic [MASK_W-1:0]         s_ready_mask    = '0;
    logic                      m_valid;
    logic                      m_ready         = 1'b0;
    logic [CLIENT_OUT_W-1:0]   m_ready_client;
    logic                      m_present;
    logic                      m_last_of_run;

    int                        mismatch_count;
    int                        results_outstanding;
    int                        cycle_count     = 0;
    logic                      pressure_due    = 1'b0;
    logic                      calm            = 1'b0;
    logic [MASK_W-1:0]         socket_written  = '0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    strict_priority_ready_select #(
        .SOCKET_COUNT      (SOCKET_COUNT),
        .CLIENT_INDEX_BITS (CLIENT_INDEX_BITS)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_socket        (s_socket),
        .s_client_number (s_client_number),
        .s_client_rank   (s_client_rank),
        .s_ready_mask    (s_ready_mask),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ready_client  (m_ready_client),
        .m_present       (m_present),
        .m_last_of_run   (m_last_of_run)
    );

    strict_priority_ready_select_checker #(
        .SOCKET_COUNT      (SOCKET_COUNT),
        .CLIENT_INDEX_BITS (CLIENT_INDEX_BITS)
    ) i_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_operation         (s_operation),
        .s_socket            (s_socket),
        .s_client_number     (s_client_number),
        .s_client_rank       (s_client_rank),
        .s_ready_mask        (s_ready_mask),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_ready_client      (m_ready_client),
        .m_present           (m_present),
        .m_last_of_run       (m_last_of_run),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding)
    );

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("strict_priority_ready_select test failed");
            $finish;
        end
    end

    // result side: short stalls, one long hold-off, none once calm
    initial begin : result_pacing
        bit held_once;
        held_once = 1'b0;
        forever begin
            @(posedge aclk);
            if (pressure_due && !held_once) begin
                held_once = 1'b1;
                m_ready <= 1'b0;
                repeat (PRESSURE_CYCLES - 1) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // present one item and wait for it to be taken
    task automatic offer_item(input logic op, input logic [SOCKET_W-1:0] sock,
                              input logic [CLIENT_OUT_W-1:0] client,
                              input logic signed [RANK_W-1:0] rank,
                              input logic [MASK_W-1:0] mask);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_operation     <= op;
        s_socket        <= sock;
        s_client_number <= client;
        s_client_rank   <= rank;
        s_ready_mask    <= mask;
        s_valid         <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (op == OP_WRITE)
            socket_written[sock] = 1'b1;
    endtask

    // table write, scan fields filled with noise
    task automatic write_entry(input logic [SOCKET_W-1:0] sock,
                               input logic [CLIENT_OUT_W-1:0] client,
                               input logic signed [RANK_W-1:0] rank);
        offer_item(OP_WRITE, sock, client, rank, {$urandom, $urandom});
    endtask

    // scan, write fields filled with noise
    task automatic scan_sockets(input logic [MASK_W-1:0] mask);
        offer_item(OP_SCAN, SOCKET_W'($urandom), CLIENT_OUT_W'($urandom),
                   RANK_W'($urandom), mask);
    endtask

    // ranks: extremes, a narrow band around zero for ties, or anything
    function automatic logic signed [RANK_W-1:0] next_rank();
        logic signed [RANK_W-1:0] r;
        case ($urandom_range(0, 3))
            0: r = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            1: r = RANK_W'($urandom_range(0, 4) - 2);
            default: r = RANK_W'($urandom);
        endcase
        return r;
    endfunction

    // masks: empty, full, a few sockets, or anything
    function automatic logic [MASK_W-1:0] next_mask();
        logic [MASK_W-1:0] m;
        case ($urandom_range(0, 9))
            0: m = '0;
            1: m = '1;
            2, 3, 4: begin
                m = '0;
                repeat ($urandom_range(1, 3)) m[$urandom_range(0, MASK_W - 1)] = 1'b1;
            end
            default: m = {$urandom, $urandom};
        endcase
        return m;
    endfunction

    // one random item, scans limited to sockets already written
    task automatic random_request();
        if ($urandom_range(0, 9) < 3)
            write_entry(SOCKET_W'($urandom_range(0, SOCKET_COUNT - 1)),
                        CLIENT_OUT_W'($urandom), next_rank());
        else
            scan_sockets(next_mask() & socket_written);
    endtask

    // stop offering, let every result out, then let the block settle
    task automatic wait_until_quiet();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_strict_mode(input logic strict);
        cfg_data  <= strict;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int fill_order [SOCKET_COUNT];
        int pick;
        int swap;
        int sent;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, empty scan, equal top ranks, negative ranks
        write_entry(6'd0, 7'd127, 16'h7FFF);
        write_entry(6'd63, 7'd0, 16'h8000);
        write_entry(6'd1, 7'd85, 16'h0000);
        write_entry(6'd62, 7'd42, 16'hFFFF);
        write_entry(6'd2, 7'd5, 16'h7FFF);
        scan_sockets(64'h0);
        scan_sockets(64'hC000_0000_0000_0007);
        scan_sockets(64'h8000_0000_0000_0000);
        scan_sockets(64'hC000_0000_0000_0000);
        scan_sockets(64'hC000_0000_0000_0002);
        // directed: all ready sockets returned
        wait_until_quiet();
        set_strict_mode(1'b0);
        scan_sockets(64'hC000_0000_0000_0007);
        scan_sockets(64'h0);
        scan_sockets(64'h8000_0000_0000_0000);

        // random phases, each under its own mode setting
        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_until_quiet();
            set_strict_mode(PHASE_STRICT[p]);
            if (p == 1)
                pressure_due <= 1'b1;
            if (p == PHASE_COUNT - 1)
                calm <= 1'b1;
            sent = 0;
            // first phase fills the whole table in shuffled order
            if (p == 0) begin
                for (int s = 0; s < SOCKET_COUNT; s++)
                    fill_order[s] = s;
                for (int s = SOCKET_COUNT - 1; s > 0; s--) begin
                    pick             = $urandom_range(0, s);
                    swap             = fill_order[s];
                    fill_order[s]    = fill_order[pick];
                    fill_order[pick] = swap;
                end
                for (int s = 0; s < SOCKET_COUNT; s++) begin
                    if (!socket_written[fill_order[s]]) begin
                        write_entry(SOCKET_W'(fill_order[s]), CLIENT_OUT_W'($urandom),
                                    next_rank());
                        sent++;
                    end
                end
            end
            for (; sent < PHASE_ITEMS; sent++)
                random_request();
        end

        wait_until_quiet();
        if (mismatch_count == 0)
            $display("strict_priority_ready_select test passed");
        else
            $display("strict_priority_ready_select test failed");
        $finish;
    end

endmodule
